@@ hw/rtl/msl_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// msl_pkg: types and constants of the MOESI snoop line controller
//
// Word layouts on both channels, opcode and bus request codes, the one-hot
// line state and its mapping onto the 4-bit state code reported per word.
// ---------------------------------------------------------------------------
package msl_pkg;

	localparam int ADDR_BITS = 32;
	localparam int NODE_BITS = 4;

	// Input opcodes; the remaining codes are illegal
	localparam logic [2:0] OP_LOAD  = 3'd0;
	localparam logic [2:0] OP_STORE = 3'd1;
	localparam logic [2:0] OP_GETS  = 3'd2;
	localparam logic [2:0] OP_GETM  = 3'd3;
	localparam logic [2:0] OP_DATA  = 3'd4;

	// Bus request codes
	localparam logic [1:0] REQ_NONE = 2'd0;
	localparam logic [1:0] REQ_GETS = 2'd1;
	localparam logic [1:0] REQ_GETM = 2'd2;

	// Reported state codes
	localparam logic [3:0] CODE_I  = 4'd0;
	localparam logic [3:0] CODE_S  = 4'd1;
	localparam logic [3:0] CODE_E  = 4'd2;
	localparam logic [3:0] CODE_O  = 4'd3;
	localparam logic [3:0] CODE_M  = 4'd4;
	localparam logic [3:0] CODE_IS = 4'd5;
	localparam logic [3:0] CODE_IM = 4'd6;
	localparam logic [3:0] CODE_MS = 4'd7;
	localparam logic [3:0] CODE_OM = 4'd8;

	// Line state, one-hot
	typedef enum logic [8:0] {
		ST_I  = 9'b000000001,
		ST_S  = 9'b000000010,
		ST_E  = 9'b000000100,
		ST_O  = 9'b000001000,
		ST_M  = 9'b000010000,
		ST_IS = 9'b000100000,
		ST_IM = 9'b001000000,
		ST_MS = 9'b010000000,
		ST_OM = 9'b100000000
	} msl_state_t;

	typedef struct packed {
		logic [2:0]           op;
		logic [ADDR_BITS-1:0] line_address;
		logic [NODE_BITS-1:0] source_node;
		logic                 shared_seen;
	} msl_item_t;

	typedef struct packed {
		logic [1:0]           bus_request;
		logic [ADDR_BITS-1:0] bus_address;
		logic                 data_to_processor;
		logic                 data_on_bus;
		logic [NODE_BITS-1:0] data_destination;
		logic                 assert_shared;
		logic                 miss_pulse;
		logic                 upgrade_pulse;
		logic                 protocol_error;
		logic [3:0]           next_state;
	} msl_result_t;

	// Map the one-hot state onto the reported code
	function automatic logic [3:0] msl_state_code(input msl_state_t st);
		logic [3:0] code;
		unique case (st)
			ST_S:    code = CODE_S;
			ST_E:    code = CODE_E;
			ST_O:    code = CODE_O;
			ST_M:    code = CODE_M;
			ST_IS:   code = CODE_IS;
			ST_IM:   code = CODE_IM;
			ST_MS:   code = CODE_MS;
			ST_OM:   code = CODE_OM;
			default: code = CODE_I;
		endcase
		return code;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/moesi_snoop_line_controller.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// moesi_snoop_line_controller: MOESI snooping controller for one cache line
//
// Input register, transition logic and result register around the line
// state; one word in, one result word out.
// ---------------------------------------------------------------------------
// Throughput is one word per clock while the result side is not stalled:
// each accepted word gives exactly one result word, registered first in the
// input register, then in the result register, and the line state register
// updates as the result is registered, so a word may follow in every cycle.
// Stalls on the result side back up through the input register. Write
// my_node_id only while no word is in flight; cfg_ready is always high.
module moesi_snoop_line_controller (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  msl_pkg::msl_item_t           item,
	output logic                         result_valid,
	input  logic                         result_ready,
	output msl_pkg::msl_result_t         result,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [msl_pkg::NODE_BITS-1:0] cfg_data
);
	import msl_pkg::*;

	msl_item_t                item_s1;
	logic                     item_valid_s1;
	msl_result_t              result_s2;
	logic                     result_valid_s2;
	msl_state_t               state_q;
	logic [NODE_BITS-1:0]     node_id_q;
	msl_result_t              result_nxt;
	msl_state_t               state_nxt;
	logic                     advance;

	// Move a word forward when the result slot is free or being drained
	assign advance    = item_valid_s1 && (!result_valid_s2 || result_ready);
	assign item_ready = !item_valid_s1 || advance;
	assign cfg_ready  = 1'b1;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1   <= 1'b0;
			result_valid_s2 <= 1'b0;
			state_q         <= ST_I;
			node_id_q       <= '0;
		end else begin
			if (item_ready) begin
				item_valid_s1 <= item_valid;
			end
			if (advance) begin
				result_valid_s2 <= 1'b1;
				state_q         <= state_nxt;
			end else if (result_ready) begin
				result_valid_s2 <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				node_id_q <= cfg_data;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
		if (advance) begin
			result_s2 <= result_nxt;
		end
	end

	msl_decide u_decide (
		.item       (item_s1),
		.state      (state_q),
		.my_node_id (node_id_q),
		.result     (result_nxt),
		.state_nxt  (state_nxt)
	);

	assign result_valid = result_valid_s2;
	assign result       = result_s2;

	// Held result always reports the state the line is in now
	a_state_matches: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.next_state == msl_state_code(state_q))
		else $error("result next_state disagrees with line state");

	// Destination is only driven with bus data
	a_dest_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.data_on_bus |-> result.data_destination == '0)
		else $error("data_destination set without data_on_bus");

	// A silent upgrade always lands in M
	a_upgrade_to_m: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.upgrade_pulse |-> result.next_state == CODE_M)
		else $error("upgrade without move to M");

	// An error never issues a bus request
	a_error_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.protocol_error |-> result.bus_request == REQ_NONE)
		else $error("bus request issued alongside protocol error");

endmodule
`default_nettype wire

@@ hw/rtl/msl_decide.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// msl_decide: transition and response logic
//
// Purely combinational. Takes one word and the current line state and
// forms the result word and the state that follows.
// ---------------------------------------------------------------------------
module msl_decide (
	input  msl_pkg::msl_item_t                  item,
	input  msl_pkg::msl_state_t                 state,
	input  logic [msl_pkg::NODE_BITS-1:0]       my_node_id,
	output msl_pkg::msl_result_t                result,
	output msl_pkg::msl_state_t                 state_nxt
);
	import msl_pkg::*;

	logic       is_proc;
	logic       is_store;
	logic       is_gets;
	logic       is_getm;
	logic       is_data;
	logic [1:0] req;
	logic       to_proc;
	logic       on_bus;
	logic       assert_sh;
	logic       miss;
	logic       upg;
	logic       err;

	// Decode the opcode
	assign is_proc  = (item.op == OP_LOAD) || (item.op == OP_STORE);
	assign is_store = (item.op == OP_STORE);
	assign is_gets  = (item.op == OP_GETS);
	assign is_getm  = (item.op == OP_GETM);
	assign is_data  = (item.op == OP_DATA);

	// Walk the protocol table
	always_comb begin
		req       = REQ_NONE;
		to_proc   = 1'b0;
		on_bus    = 1'b0;
		assert_sh = 1'b0;
		miss      = 1'b0;
		upg       = 1'b0;
		err       = 1'b0;
		state_nxt = state;
		if (is_proc) begin
			// Processor requests in transient states are dropped
			unique case (state)
				ST_I: begin
					req       = is_store ? REQ_GETM : REQ_GETS;
					state_nxt = is_store ? ST_IM : ST_IS;
					miss      = 1'b1;
				end
				ST_S, ST_O: begin
					if (is_store) begin
						req       = REQ_GETM;
						state_nxt = (state == ST_S) ? ST_MS : ST_OM;
						miss      = 1'b1;
					end else begin
						to_proc = 1'b1;
					end
				end
				ST_E: begin
					to_proc = 1'b1;
					if (is_store) begin
						state_nxt = ST_M;
						upg       = 1'b1;
					end
				end
				ST_M: begin
					to_proc = 1'b1;
				end
				default: begin
				end
			endcase
		end else if (is_gets || is_getm || is_data) begin
			unique case (state)
				ST_S: begin
					if (is_gets) begin
						assert_sh = 1'b1;
					end else if (is_getm) begin
						state_nxt = ST_I;
					end else begin
						err = 1'b1;
					end
				end
				ST_O: begin
					if (is_gets) begin
						assert_sh = 1'b1;
						on_bus    = 1'b1;
					end else if (is_getm) begin
						on_bus    = 1'b1;
						state_nxt = ST_I;
					end else begin
						err = 1'b1;
					end
				end
				ST_E, ST_M: begin
					if (is_gets) begin
						assert_sh = 1'b1;
						on_bus    = 1'b1;
						state_nxt = (state == ST_M) ? ST_O : ST_S;
					end else if (is_getm) begin
						assert_sh = 1'b1;
						on_bus    = 1'b1;
						state_nxt = ST_I;
					end else begin
						err = 1'b1;
					end
				end
				ST_IS: begin
					if (is_data) begin
						to_proc   = 1'b1;
						state_nxt = item.shared_seen ? ST_S : ST_E;
					end
				end
				ST_IM: begin
					if (is_data) begin
						to_proc   = 1'b1;
						state_nxt = ST_M;
					end
				end
				ST_MS: begin
					if (is_gets) begin
						assert_sh = 1'b1;
					end else if (is_getm) begin
						// Our own GETM seen on the bus keeps the upgrade alive
						if (item.source_node != my_node_id) begin
							state_nxt = ST_IM;
						end
					end else begin
						to_proc   = 1'b1;
						state_nxt = ST_M;
					end
				end
				ST_OM: begin
					if (is_gets) begin
						assert_sh = 1'b1;
						on_bus    = 1'b1;
					end else if (is_getm) begin
						on_bus    = 1'b1;
						state_nxt = ST_IM;
					end else begin
						to_proc   = 1'b1;
						state_nxt = ST_M;
					end
				end
				default: begin
					// Invalid line ignores all snoops
					state_nxt = ST_I;
				end
			endcase
		end else begin
			err = 1'b1;
		end
	end

	// Pack the result word
	always_comb begin
		result.bus_request       = req;
		result.bus_address       = ((req != REQ_NONE) || on_bus || to_proc) ?
			item.line_address : '0;
		result.data_to_processor = to_proc;
		result.data_on_bus       = on_bus;
		result.data_destination  = on_bus ? item.source_node : '0;
		result.assert_shared     = assert_sh;
		result.miss_pulse        = miss;
		result.upgrade_pulse     = upg;
		result.protocol_error    = err;
		result.next_state        = msl_state_code(state_nxt);
	end

endmodule
`default_nettype wire

@@ tb/sv/msl_tb_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// msl_tb_pkg: line state tracking and result checking for the MOESI bench
//
// Tracks the line state and the node id in step with the words accepted by
// the controller, computes the result word each one must give, and compares
// the result words in order against those expectations.
// ---------------------------------------------------------------------------
package msl_tb_pkg;

	import msl_pkg::*;

	class line_coherence_checker;

		logic [3:0]  line_code = CODE_I;
		logic [3:0]  node_id = '0;
		msl_result_t pending_results[$];
		int          mismatch_count = 0;

		// Compute the result of one word from the tracked state; no update here
		function msl_result_t predict_outcome(msl_item_t it);
			msl_result_t r;
			logic [3:0]  st;
			bit          store;
			bit          to_proc;
			bit          on_bus;
			r = '0;
			st = (line_code > CODE_OM) ? CODE_I : line_code;
			store = (it.op == OP_STORE);
			to_proc = 1'b0;
			on_bus = 1'b0;
			case (it.op)
				OP_LOAD, OP_STORE: begin
					case (st)
						CODE_I: begin
							r.bus_request = store ? REQ_GETM : REQ_GETS;
							st = store ? CODE_IM : CODE_IS;
							r.miss_pulse = 1'b1;
						end
						CODE_S, CODE_O: begin
							if (store) begin
								r.bus_request = REQ_GETM;
								st = (st == CODE_S) ? CODE_MS : CODE_OM;
								r.miss_pulse = 1'b1;
							end else begin
								to_proc = 1'b1;
							end
						end
						CODE_E: begin
							to_proc = 1'b1;
							if (store) begin
								st = CODE_M;
								r.upgrade_pulse = 1'b1;
							end
						end
						CODE_M: to_proc = 1'b1;
						// transient states drop processor requests
						default: ;
					endcase
				end
				OP_GETS, OP_GETM, OP_DATA: begin
					case (st)
						CODE_S: begin
							case (it.op)
								OP_GETS: r.assert_shared = 1'b1;
								OP_GETM: st = CODE_I;
								default: r.protocol_error = 1'b1;
							endcase
						end
						CODE_O: begin
							case (it.op)
								OP_GETS: begin
									r.assert_shared = 1'b1;
									on_bus = 1'b1;
								end
								OP_GETM: begin
									on_bus = 1'b1;
									st = CODE_I;
								end
								default: r.protocol_error = 1'b1;
							endcase
						end
						CODE_E, CODE_M: begin
							case (it.op)
								OP_GETS: begin
									r.assert_shared = 1'b1;
									on_bus = 1'b1;
									st = (st == CODE_M) ? CODE_O : CODE_S;
								end
								OP_GETM: begin
									r.assert_shared = 1'b1;
									on_bus = 1'b1;
									st = CODE_I;
								end
								default: r.protocol_error = 1'b1;
							endcase
						end
						CODE_IS: begin
							if (it.op == OP_DATA) begin
								to_proc = 1'b1;
								st = it.shared_seen ? CODE_S : CODE_E;
							end
						end
						CODE_IM: begin
							if (it.op == OP_DATA) begin
								to_proc = 1'b1;
								st = CODE_M;
							end
						end
						CODE_MS: begin
							case (it.op)
								OP_GETS: r.assert_shared = 1'b1;
								// our own GETM seen on the bus keeps the upgrade going
								OP_GETM: if (it.source_node != node_id) st = CODE_IM;
								default: begin
									to_proc = 1'b1;
									st = CODE_M;
								end
							endcase
						end
						CODE_OM: begin
							case (it.op)
								OP_GETS: begin
									r.assert_shared = 1'b1;
									on_bus = 1'b1;
								end
								OP_GETM: begin
									on_bus = 1'b1;
									st = CODE_IM;
								end
								default: begin
									to_proc = 1'b1;
									st = CODE_M;
								end
							endcase
						end
						// snoops in I are dropped
						default: ;
					endcase
				end
				default: r.protocol_error = 1'b1;
			endcase
			r.data_to_processor = to_proc;
			r.data_on_bus = on_bus;
			r.data_destination = on_bus ? it.source_node : '0;
			r.bus_address = (r.bus_request != REQ_NONE || on_bus || to_proc) ?
				it.line_address : '0;
			r.next_state = st;
			return r;
		endfunction

		// Advance the tracked state by one accepted word and queue its result
		function void note_item(msl_item_t it);
			msl_result_t r;
			r = predict_outcome(it);
			line_code = r.next_state;
			pending_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				mismatch_count++;
			end
		endfunction

		// Match one result word against the oldest expectation
		function void check_result(msl_result_t got);
			msl_result_t want;
			if (pending_results.size() == 0) begin
				$error("result word with nothing expected: %h", got);
				mismatch_count++;
				return;
			end
			want = pending_results.pop_front();
			compare_field("bus_request", 32'(want.bus_request), 32'(got.bus_request));
			compare_field("bus_address", want.bus_address, got.bus_address);
			compare_field("data_to_processor", 32'(want.data_to_processor),
				32'(got.data_to_processor));
			compare_field("data_on_bus", 32'(want.data_on_bus), 32'(got.data_on_bus));
			compare_field("data_destination", 32'(want.data_destination),
				32'(got.data_destination));
			compare_field("assert_shared", 32'(want.assert_shared),
				32'(got.assert_shared));
			compare_field("miss_pulse", 32'(want.miss_pulse), 32'(got.miss_pulse));
			compare_field("upgrade_pulse", 32'(want.upgrade_pulse),
				32'(got.upgrade_pulse));
			compare_field("protocol_error", 32'(want.protocol_error),
				32'(got.protocol_error));
			compare_field("next_state", 32'(want.next_state), 32'(got.next_state));
		endfunction

	endclass

endpackage

@@ tb/sv/tb_moesi_snoop_line_controller.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_moesi_snoop_line_controller: bench for the MOESI snoop line controller
//
// Walks the line through every stable and transient state with a directed
// word sequence, then runs biased random words in four phases that each write
// a node id and use different amounts of sender idling and receiver stalling,
// including one long receiver hold-off. Every result word is checked field
// by field against the tracked line state.
// ---------------------------------------------------------------------------
module tb_moesi_snoop_line_controller;

	import msl_pkg::*;
	import msl_tb_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	msl_item_t   item = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	msl_result_t result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [NODE_BITS-1:0] cfg_data = '0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit long_hold = 1'b0;

	line_coherence_checker board;

	moesi_snoop_line_controller u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: random stalls, and one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (long_hold) begin
				long_hold = 1'b0;
				result_ready <= 1'b0;
				repeat (80) @(posedge clk);
			end
			result_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Check every result word as it is taken
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) board.check_result(result);
	end

	// Offer one word after a random gap; hold it until taken
	task automatic send_item(input msl_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		board.note_item(it);
	endtask

	task automatic directed_item(input logic [2:0] op, input logic [31:0] addr,
		input logic [3:0] src, input logic sh);
		msl_item_t it;
		it.op = op;
		it.line_address = addr;
		it.source_node = src;
		it.shared_seen = sh;
		send_item(it);
	endtask

	// Drop valid, wait for all results, then let the pipeline settle
	task automatic drain();
		int n;
		n = 0;
		item_valid <= 1'b0;
		while (board.pending_results.size() != 0 && n < 20000) begin
			@(posedge clk);
			n++;
		end
		repeat (6) @(posedge clk);
	endtask

	task automatic write_node_id(input logic [3:0] id);
		cfg_valid <= 1'b1;
		cfg_data <= id;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		board.node_id = id;
	endtask

	// Random word biased toward moving the line: data in transient states,
	// and snoops that often come from this node
	function automatic msl_item_t random_item();
		msl_item_t it;
		int pick;
		pick = $urandom_range(99);
		if (board.line_code >= CODE_IS && $urandom_range(99) < 55) it.op = OP_DATA;
		else if (pick < 22) it.op = OP_LOAD;
		else if (pick < 44) it.op = OP_STORE;
		else if (pick < 60) it.op = OP_GETS;
		else if (pick < 76) it.op = OP_GETM;
		else if (pick < 94) it.op = OP_DATA;
		else it.op = 3'($urandom_range(7, 5));
		it.line_address = $urandom;
		it.source_node = ($urandom_range(3) == 0) ? board.node_id : 4'($urandom_range(15));
		it.shared_seen = 1'($urandom_range(1));
		return it;
	endfunction

	initial begin
		msl_item_t   it;
		int          phase;
		int          moved;
		bit          hold_done;
		int          send_pct[4];
		int          stall_pct[4];
		logic [3:0]  phase_ids[4];

		board = new();
		send_pct = '{0, 48, 0, 29};
		stall_pct = '{0, 0, 48, 29};
		phase_ids = '{4'h0, 4'($urandom_range(14, 1)), 4'hF, 4'($urandom_range(15))};
		hold_done = 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_node_id(4'hF);

		// Walk the line through every state
		directed_item(OP_LOAD, 32'h0000_0000, 4'h0, 1'b0);
		directed_item(OP_STORE, 32'h1234_5678, 4'h1, 1'b1);
		directed_item(OP_DATA, 32'hFFFF_FFFF, 4'hF, 1'b0);
		directed_item(OP_STORE, 32'hA5A5_A5A5, 4'h2, 1'b0);
		directed_item(OP_DATA, 32'h5A5A_5A5A, 4'h3, 1'b1);
		directed_item(OP_GETS, 32'hDEAD_BEEF, 4'hF, 1'b0);
		directed_item(OP_LOAD, 32'h0000_0001, 4'h0, 1'b0);
		directed_item(OP_STORE, 32'h8000_0000, 4'h4, 1'b0);
		directed_item(OP_LOAD, 32'h7FFF_FFFF, 4'h5, 1'b0);
		directed_item(OP_GETS, 32'hCAFE_F00D, 4'h0, 1'b1);
		directed_item(OP_DATA, 32'h0F0F_0F0F, 4'h6, 1'b1);
		directed_item(OP_GETM, 32'hF0F0_F0F0, 4'hA, 1'b0);
		directed_item(OP_DATA, 32'h1111_1111, 4'h7, 1'b0);
		directed_item(3'd5, 32'h2222_2222, 4'h8, 1'b0);
		directed_item(3'd6, 32'h3333_3333, 4'h9, 1'b1);
		directed_item(3'd7, 32'hFFFF_FFFF, 4'hF, 1'b1);
		directed_item(OP_STORE, 32'h4444_4444, 4'hB, 1'b0);
		directed_item(OP_GETS, 32'h5555_5555, 4'hC, 1'b0);
		directed_item(OP_DATA, 32'h6666_6666, 4'hD, 1'b0);
		directed_item(OP_GETS, 32'h7777_7777, 4'h1, 1'b0);
		directed_item(OP_GETM, 32'h8888_8888, 4'h5, 1'b0);
		directed_item(OP_LOAD, 32'h9999_9999, 4'h0, 1'b0);
		directed_item(OP_DATA, 32'hAAAA_AAAA, 4'hE, 1'b1);
		directed_item(OP_STORE, 32'hBBBB_BBBB, 4'h0, 1'b0);
		directed_item(OP_GETS, 32'hCCCC_CCCC, 4'h6, 1'b0);
		directed_item(OP_GETM, 32'hDDDD_DDDD, 4'hF, 1'b0);
		directed_item(OP_GETM, 32'hEEEE_EEEE, 4'h3, 1'b0);
		directed_item(OP_DATA, 32'h0000_FFFF, 4'h0, 1'b1);
		drain();

		// Random phases of a fixed word count each
		for (phase = 0; phase < 4; phase++) begin
			write_node_id(phase_ids[phase]);
			send_idle_pct = send_pct[phase];
			recv_stall_pct = stall_pct[phase];
			moved = 0;
			while (moved < 105) begin
				it = random_item();
				send_item(it);
				moved++;
				if (phase == 0 && moved == 40 && !hold_done) begin
					long_hold = 1'b1;
					hold_done = 1'b1;
				end
			end
			drain();
		end

		if (board.pending_results.size() != 0) begin
			$error("%0d result words never arrived", board.pending_results.size());
			board.mismatch_count++;
		end
		if (board.mismatch_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Hard stop if the run hangs
	initial begin
		#3ms;
		$display("tb: failure");
		$finish;
	end

endmodule
